[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the date adder modules.
// Each macro expects a signal named clock and a signal named reset in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/gda_pkg.sv]
// ---------------------------------------------------------------------------
// gda_pkg
// Widths, calendar constants, command and status types and the month length
// function shared by the date adder controller and datapath.
// ---------------------------------------------------------------------------
package gda_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int DAYS_W   = 16;
   localparam int TOTAL_W  = 17;
   localparam int LEN_W    = 5;
   localparam int MOD_W    = 9;
   localparam int QUOT_W   = 6;
   localparam int PROD_W   = 28;
   localparam int SUB_W    = 15;

   // floor(year / 400) = (year * RECIP_400) >> RECIP_SHIFT for any 14-bit year.
   localparam int RECIP_400   = 10486;
   localparam int RECIP_SHIFT = 22;

   localparam int YEAR_MOD     = 400;
   localparam int CENTURY      = 100;
   localparam int MONTHS       = 12;

   localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] M_APR = 4'd4;
   localparam logic [MONTH_W-1:0] M_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] M_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] M_NOV = 4'd11;

   localparam logic [LEN_W-1:0] LEN_LEAP_FEB = 5'd29;
   localparam logic [LEN_W-1:0] LEN_FEB      = 5'd28;
   localparam logic [LEN_W-1:0] LEN_SHORT    = 5'd30;
   localparam logic [LEN_W-1:0] LEN_LONG     = 5'd31;

   typedef struct packed {
      logic load;
      logic quot;
      logic modr;
      logic step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
   } dp_stat_type;

   function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [LEN_W-1:0] len;
      case (month)
         M_APR, M_JUN, M_SEP, M_NOV: len = LEN_SHORT;
         M_FEB:                      len = leap ? LEN_LEAP_FEB : LEN_FEB;
         default:                    len = LEN_LONG;
      endcase
      return len;
   endfunction

endpackage

[rtl/gda_dp.sv]
// ---------------------------------------------------------------------------
// gda_dp
// Datapath of the date adder: working date registers, a year-mod-400 tracker
// for the leap test, one month step per command and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gda_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  gda_pkg::dp_cmd_type           cmd,
   output gda_pkg::dp_stat_type          stat,
   input  logic [gda_pkg::YEAR_W-1:0]    req_start_year,
   input  logic [gda_pkg::MONTH_W-1:0]   req_start_month,
   input  logic [gda_pkg::DAY_W-1:0]     req_start_day,
   input  logic [gda_pkg::DAYS_W-1:0]    req_days_to_add,
   output logic [gda_pkg::YEAR_W-1:0]    rsp_result_year,
   output logic [gda_pkg::MONTH_W-1:0]   rsp_result_month,
   output logic [gda_pkg::DAY_W-1:0]     rsp_result_day
);
   import gda_pkg::*;

   logic [YEAR_W-1:0]  year_ff,  year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [MOD_W-1:0]   mod_ff,   mod_in;
   logic [QUOT_W-1:0]  quot_ff,  quot_in;
   logic [YEAR_W-1:0]  res_year_ff;
   logic [MONTH_W-1:0] res_month_ff;
   logic [DAY_W-1:0]   res_day_ff;

   logic [PROD_W-1:0]  prod;
   logic [SUB_W-1:0]   sub;
   logic               leap;
   logic [LEN_W-1:0]   len;
   logic [MONTH_W-1:0] month_inc;
   logic               wrap;

   assign prod    = PROD_W'(year_ff) * PROD_W'(RECIP_400);
   assign quot_in = prod[RECIP_SHIFT +: QUOT_W];
   assign sub     = SUB_W'(year_ff) - SUB_W'(quot_ff) * SUB_W'(YEAR_MOD);

   // Divisible by 4, and not a century unless the year is a multiple of 400.
   assign leap = (year_ff[1:0] == 2'b00) &&
                 (mod_ff != MOD_W'(CENTURY)) &&
                 (mod_ff != MOD_W'(2 * CENTURY)) &&
                 (mod_ff != MOD_W'(3 * CENTURY));

   assign len       = month_len(month_ff, leap);
   assign stat.done = (total_ff <= TOTAL_W'(len));
   assign month_inc = month_ff + MONTH_W'(1);
   assign wrap      = (month_inc > MONTH_W'(MONTHS)) || (month_inc == '0);

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      total_in = total_ff;
      mod_in   = mod_ff;
      if (cmd.load) begin
         year_in  = req_start_year;
         month_in = req_start_month;
         total_in = TOTAL_W'(req_start_day) + TOTAL_W'(req_days_to_add);
      end else if (cmd.modr) begin
         mod_in = sub[MOD_W-1:0];
      end else if (cmd.step) begin
         total_in = total_ff - TOTAL_W'(len);
         month_in = month_inc;
         if (wrap) begin
            month_in = M_JAN;
            year_in  = year_ff + YEAR_W'(1);
            // The year wraps to zero at the top of its range; zero is a multiple of 400.
            if (year_ff == '1 || mod_ff == MOD_W'(YEAR_MOD - 1)) begin
               mod_in = '0;
            end else begin
               mod_in = mod_ff + MOD_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      month_ff <= month_in;
      total_ff <= total_in;
      mod_ff   <= mod_in;
      if (cmd.quot) begin
         quot_ff <= quot_in;
      end
      if (reset) begin
         res_year_ff  <= '0;
         res_month_ff <= '0;
         res_day_ff   <= '0;
      end else if (cmd.emit) begin
         res_year_ff  <= year_ff;
         res_month_ff <= month_ff;
         res_day_ff   <= total_ff[DAY_W-1:0];
      end
   end

   assign rsp_result_year  = res_year_ff;
   assign rsp_result_month = res_month_ff;
   assign rsp_result_day   = res_day_ff;

   `ASSERT_NEXT(a_mod_range, cmd.modr, mod_ff < MOD_W'(YEAR_MOD), "year remainder out of range")
   `ASSERT_IMPL(a_mod_leap, cmd.step && mod_ff == '0, year_ff[1:0] == 2'b00,
                "year remainder disagrees with year")
   `ASSERT_NEXT(a_res_hold, !cmd.emit && !reset, $stable(res_year_ff) && $stable(res_day_ff),
                "result changed without an emit")

endmodule

[rtl/gda_ctrl.sv]
// ---------------------------------------------------------------------------
// gda_ctrl
// Controller of the date adder: sequences load, leap setup and the month walk,
// and owns the result valid flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gda_pkg::dp_cmd_type   cmd,
   input  gda_pkg::dp_stat_type  stat
);
   import gda_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_QUOT = 2'd1;
   localparam logic [1:0] ST_MODR = 2'd2;
   localparam logic [1:0] ST_WALK = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load = req_valid && req_ready;
      cmd.quot = (state_ff == ST_QUOT);
      cmd.modr = (state_ff == ST_MODR);
      cmd.step = (state_ff == ST_WALK) && !stat.done;
      // The finished date moves out once the result register is free or being drained.
      cmd.emit = (state_ff == ST_WALK) && stat.done && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (cmd.load) state_in = ST_QUOT;
         ST_QUOT: state_in = ST_MODR;
         ST_MODR: state_in = ST_WALK;
         ST_WALK: if (cmd.emit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_load_seq, cmd.load, state_ff == ST_QUOT, "load did not start leap setup")
   `ASSERT_NEXT(a_walk_stay, (state_ff == ST_WALK) && !stat.done, state_ff == ST_WALK,
                "walk left before the date was done")
   `ASSERT_NEXT(a_emit_valid, cmd.emit, rsp_valid_ff, "emitted result not flagged valid")

endmodule

[rtl/gregorian_date_add_days.sv]
// ---------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date by walking one month per cycle.
//
//   channel  direction  fields
//   req      in         start_year, start_month, start_day, days_to_add
//   rsp      out        result_year, result_month, result_day
//
// An item passes from acceptance to the result register through the QUOT and
// MODR states and a walk of M months (M up to about 2160); the walk retires one
// month per cycle through a single subtract-and-compare step. QUOT and MODR
// derive the year modulo 400 (a reciprocal multiply, then a multiply back and
// subtract); the date enters the result register once it is free or draining.
// A new beat is taken once the previous walk has handed its date to the
// result register, which may still be waiting on rsp_ready.
// Reset is synchronous and clears the control state and the result register.
// ---------------------------------------------------------------------------
module gregorian_date_add_days (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gda_pkg::YEAR_W-1:0]    req_start_year,
   input  logic [gda_pkg::MONTH_W-1:0]   req_start_month,
   input  logic [gda_pkg::DAY_W-1:0]     req_start_day,
   input  logic [gda_pkg::DAYS_W-1:0]    req_days_to_add,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gda_pkg::YEAR_W-1:0]    rsp_result_year,
   output logic [gda_pkg::MONTH_W-1:0]   rsp_result_month,
   output logic [gda_pkg::DAY_W-1:0]     rsp_result_day
);
   import gda_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   gda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   gda_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_start_year   (req_start_year),
      .req_start_month  (req_start_month),
      .req_start_day    (req_start_day),
      .req_days_to_add  (req_days_to_add),
      .rsp_result_year  (rsp_result_year),
      .rsp_result_month (rsp_result_month),
      .rsp_result_day   (rsp_result_day)
   );

endmodule
